FILE: sv/bitmap_page_allocator_assert.svh
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_HOLDS(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bitmap page allocator check failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bitmap page allocator check failed");

`endif

FILE: sv/bpa_pkg.sv
package bpa_pkg;

  localparam int unsigned NUM_BLOCKS    = 32768;
  localparam int unsigned BLOCK_BYTES   = 4096;
  localparam int unsigned BLOCK_SHIFT   = $clog2(BLOCK_BYTES);
  localparam int unsigned MAP_WORD_BITS = 32;
  localparam int unsigned MAP_WORDS     = NUM_BLOCKS / MAP_WORD_BITS;
  localparam int unsigned WORD_AW       = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int unsigned IDX_W         = $clog2(NUM_BLOCKS) + 1;
  localparam int unsigned PAGE_W        = 32 - BLOCK_SHIFT;
  localparam int unsigned CFG_AW        = 3;

  localparam logic [15:0] MAX_BLOCKS_RESET = 16'd32768;

  localparam logic [2:0] REQ_INIT           = 3'd0;
  localparam logic [2:0] REQ_ALLOC          = 3'd1;
  localparam logic [2:0] REQ_FREE_BLOCK     = 3'd2;
  localparam logic [2:0] REQ_ADD_REGION     = 3'd3;
  localparam logic [2:0] REQ_RESERVE_REGION = 3'd4;
  localparam logic [2:0] REQ_FREE_REGION    = 3'd5;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  localparam logic REG_MAX_BLOCKS = 1'b0;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] addr;
    logic [31:0] size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] block_addr;
    logic [15:0] used_count;
  } out_item_t;

  typedef struct packed {
    logic                     rd_en;
    logic [WORD_AW-1:0]       rd_addr;
    logic                     wr_en;
    logic [WORD_AW-1:0]       wr_addr;
    logic [MAP_WORD_BITS-1:0] wr_data;
  } map_req_t;

endpackage

FILE: sv/bpa_map_ram.sv
module bpa_map_ram (
  input  logic                              clk,
  input  bpa_pkg::map_req_t                 req,
  output logic [bpa_pkg::MAP_WORD_BITS-1:0] rd_data_r
);
  import bpa_pkg::*;

  logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

FILE: sv/bpa_ctrl.sv
module bpa_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bpa_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bpa_pkg::out_item_t                out_data,
  input  logic [15:0]                       max_blocks,
  output bpa_pkg::map_req_t                 map_req,
  input  logic [bpa_pkg::MAP_WORD_BITS-1:0] map_rd_data
);
  import bpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_RANGE, S_CHECK, S_SCAN, S_FILL, S_DONE
  } state_t;

  localparam logic [31:0] OFS      = 32'(BLOCK_BYTES - 1);
  localparam logic [31:0] BLK_MASK = ~OFS;

  function automatic logic [BIT_W-1:0] low_bit(input logic [MAP_WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  state_t             state_r;
  logic [2:0]         req_r;
  logic [31:0]        addr_r;
  logic [31:0]        size_r;
  logic [31:0]        sum_r;
  logic [31:0]        start_r;
  logic [31:0]        end_r;
  logic [IDX_W-1:0]   lo_r;
  logic [IDX_W-1:0]   hi_r;
  logic [WORD_AW-1:0] rd_ptr_r;
  logic               rd_done_r;
  logic               pend_r;
  logic [WORD_AW-1:0] pend_w_r;
  logic               phase_r;
  logic [1:0]         status_r;
  logic [31:0]        baddr_r;
  logic [15:0]        used_r;
  logic [IDX_W-1:0]   hint_r;
  logic               ready_r;
  logic [IDX_W-1:0]   limit_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [IDX_W-1:0]         hi_m1;
  logic [WORD_AW-1:0]       lo_w;
  logic [WORD_AW-1:0]       last_w;
  logic [MAP_WORD_BITS-1:0] lo_mask;
  logic [MAP_WORD_BITS-1:0] hi_mask;
  logic [MAP_WORD_BITS-1:0] mask;
  logic [MAP_WORD_BITS-1:0] clr_bits;
  logic [MAP_WORD_BITS-1:0] set_bits;
  logic [MAP_WORD_BITS-1:0] tgt_bits;
  logic [BIT_W-1:0]         tgt_bit;
  logic [IDX_W-1:0]         tgt_idx;
  logic [BIT_W:0]           pop;
  logic [15:0]              used_sub;
  logic                     is_alloc;
  logic                     is_set;
  logic                     lower_hint;
  logic                     found;
  logic [PAGE_W-1:0]        first_pg;
  logic [PAGE_W-1:0]        end_pg;
  logic [PAGE_W-1:0]        fb_pg;
  logic [IDX_W-1:0]         last_cl;
  logic                     rng_ign;
  logic [IDX_W-1:0]         lim_sat;

  assign hi_m1    = hi_r - 1'b1;
  assign lo_w     = lo_r[IDX_W-2:BIT_W];
  assign last_w   = hi_m1[IDX_W-2:BIT_W];
  assign lo_mask  = (pend_w_r == lo_w) ? ({MAP_WORD_BITS{1'b1}} << lo_r[BIT_W-1:0])
                                       : {MAP_WORD_BITS{1'b1}};
  assign hi_mask  = (pend_w_r == last_w) ? ({MAP_WORD_BITS{1'b1}} >> (~hi_m1[BIT_W-1:0]))
                                         : {MAP_WORD_BITS{1'b1}};
  assign mask     = lo_mask & hi_mask;
  assign clr_bits = map_rd_data & mask;
  assign set_bits = ~map_rd_data & mask;
  assign is_alloc   = (req_r == REQ_ALLOC);
  assign is_set     = (req_r == REQ_RESERVE_REGION);
  assign lower_hint = (req_r == REQ_FREE_BLOCK) || (req_r == REQ_FREE_REGION);
  assign tgt_bits = (is_alloc || is_set) ? set_bits : clr_bits;
  assign found    = |tgt_bits;
  assign tgt_bit  = low_bit(tgt_bits);
  assign tgt_idx  = IDX_W'({pend_w_r, tgt_bit});
  assign pop      = (BIT_W + 1)'($countones(tgt_bits));
  assign used_sub = (used_r < 16'(pop)) ? 16'd0 : used_r - 16'(pop);

  assign first_pg = start_r[31:BLOCK_SHIFT];
  assign end_pg   = end_r[31:BLOCK_SHIFT];
  assign fb_pg    = addr_r[31:BLOCK_SHIFT];
  assign last_cl  = (end_pg > PAGE_W'(limit_r)) ? limit_r : end_pg[IDX_W-1:0];
  assign lim_sat  = (max_blocks > 16'(NUM_BLOCKS)) ? IDX_W'(NUM_BLOCKS)
                                                    : IDX_W'(max_blocks);

  always_comb begin
    priority case (req_r)
      REQ_FREE_BLOCK:  rng_ign = (fb_pg >= PAGE_W'(limit_r));
      REQ_ADD_REGION:  rng_ign = (start_r >= end_r) || (first_pg >= PAGE_W'(last_cl));
      REQ_FREE_REGION: rng_ign = (size_r == 32'd0) || (end_r <= start_r)
                                 || (first_pg >= PAGE_W'(last_cl));
      default:         rng_ign = (first_pg >= PAGE_W'(last_cl));
    endcase
  end

  always_comb begin
    map_req         = '0;
    map_req.rd_addr = rd_ptr_r;
    map_req.wr_addr = (state_r == S_FILL) ? rd_ptr_r : pend_w_r;
    if (state_r == S_FILL) begin
      map_req.wr_en   = 1'b1;
      map_req.wr_data = {MAP_WORD_BITS{1'b1}};
    end else if (state_r == S_SCAN) begin
      map_req.rd_en = !rd_done_r;
      if (pend_r) begin
        if (is_alloc) begin
          map_req.wr_en   = found;
          map_req.wr_data = map_rd_data | (MAP_WORD_BITS'(1) << tgt_bit);
        end else begin
          map_req.wr_en   = 1'b1;
          map_req.wr_data = is_set ? (map_rd_data | mask) : (map_rd_data & ~mask);
        end
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      hint_r      <= '0;
      ready_r     <= 1'b0;
      limit_r     <= IDX_W'(NUM_BLOCKS);
      out_valid_r <= 1'b0;
      rd_done_r   <= 1'b1;
      pend_r      <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r    <= in_data.req_type;
            addr_r   <= in_data.addr;
            size_r   <= in_data.size;
            baddr_r  <= '0;
            status_r <= ST_DONE;
            if (in_data.req_type > REQ_FREE_REGION) begin
              status_r <= ST_IGNORED;
              state_r  <= S_DONE;
            end else if (in_data.req_type != REQ_INIT && !ready_r) begin
              status_r <= ST_NOT_READY;
              state_r  <= S_DONE;
            end else if (in_data.req_type == REQ_INIT) begin
              rd_ptr_r <= '0;
              limit_r  <= lim_sat;
              used_r   <= 16'(lim_sat);
              hint_r   <= '0;
              ready_r  <= 1'b1;
              state_r  <= S_FILL;
            end else begin
              state_r <= S_SUM;
            end
          end
        end
        S_FILL: begin
          rd_ptr_r <= rd_ptr_r + 1'b1;
          if (rd_ptr_r == WORD_AW'(MAP_WORDS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_SUM: begin
          sum_r   <= addr_r + size_r;
          state_r <= S_RANGE;
        end
        S_RANGE: begin
          if (req_r == REQ_ADD_REGION) begin
            start_r <= (addr_r + OFS) & BLK_MASK;
            end_r   <= sum_r & BLK_MASK;
          end else begin
            start_r <= addr_r & BLK_MASK;
            end_r   <= (sum_r + OFS) & BLK_MASK;
          end
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          rd_done_r <= 1'b0;
          pend_r    <= 1'b0;
          phase_r   <= 1'b0;
          state_r   <= S_SCAN;
          if (is_alloc) begin
            if (IDX_W'(used_r) >= limit_r) begin
              status_r  <= ST_FULL;
              rd_done_r <= 1'b1;
              state_r   <= S_DONE;
            end else if (hint_r < limit_r) begin
              lo_r     <= hint_r;
              hi_r     <= limit_r;
              rd_ptr_r <= hint_r[IDX_W-2:BIT_W];
            end else begin
              lo_r     <= '0;
              hi_r     <= limit_r;
              phase_r  <= 1'b1;
              rd_ptr_r <= '0;
            end
          end else if (rng_ign) begin
            status_r  <= ST_IGNORED;
            rd_done_r <= 1'b1;
            state_r   <= S_DONE;
          end else if (req_r == REQ_FREE_BLOCK) begin
            lo_r     <= fb_pg[IDX_W-1:0];
            hi_r     <= fb_pg[IDX_W-1:0] + 1'b1;
            rd_ptr_r <= fb_pg[IDX_W-2:BIT_W];
          end else begin
            lo_r     <= first_pg[IDX_W-1:0];
            hi_r     <= last_cl;
            rd_ptr_r <= first_pg[IDX_W-2:BIT_W];
          end
        end
        S_SCAN: begin
          if (!rd_done_r) begin
            rd_ptr_r <= rd_ptr_r + 1'b1;
            pend_r   <= 1'b1;
            pend_w_r <= rd_ptr_r;
            if (rd_ptr_r == last_w) begin
              rd_done_r <= 1'b1;
            end
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) begin
            if (is_alloc) begin
              if (found) begin
                used_r    <= used_r + 1'b1;
                hint_r    <= tgt_idx + 1'b1;
                baddr_r   <= 32'({tgt_idx, {BLOCK_SHIFT{1'b0}}});
                rd_done_r <= 1'b1;
                pend_r    <= 1'b0;
                state_r   <= S_DONE;
              end else if (pend_w_r == last_w) begin
                if (!phase_r && hint_r != '0) begin
                  lo_r      <= '0;
                  hi_r      <= hint_r;
                  phase_r   <= 1'b1;
                  rd_ptr_r  <= '0;
                  rd_done_r <= 1'b0;
                  pend_r    <= 1'b0;
                end else begin
                  status_r <= ST_FULL;
                  state_r  <= S_DONE;
                end
              end
            end else begin
              if (is_set) begin
                used_r <= used_r + 16'(pop);
              end else begin
                used_r <= used_sub;
              end
              if (lower_hint && found && tgt_idx < hint_r) begin
                hint_r <= tgt_idx;
              end
              if (pend_w_r == last_w) begin
                state_r <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r           <= 1'b1;
            out_data_r.status     <= status_r;
            out_data_r.block_addr <= baddr_r;
            out_data_r.used_count <= used_r;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/bitmap_page_allocator.sv
// Bitmap page allocator: one bit per 4 KiB block in a 1024 x 32 map RAM, a set bit meaning
// used, with a used-block count and a next-fit hint. One request is in progress at a time and
// gives one result transfer; a finished result may wait in the output register while the next
// request is taken. Cost is set by the map RAM, which is read, modified and written back one
// 32-bit word per cycle: unknown or not-ready requests go straight to the result, init sets
// every map word, free_block and region requests visit each map word the clamped range covers,
// and alloc scans words from the hint onwards, then from the bottom of the map if it has to
// wrap. No request other than init is served before the first init.
module bitmap_page_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bpa_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bpa_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpa_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bpa_pkg::*;

  logic [15:0]              max_blocks_r;
  map_req_t                 map_req;
  logic [MAP_WORD_BITS-1:0] map_rd_data;

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1:2] == REG_MAX_BLOCKS) ? 32'(max_blocks_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_blocks_r <= MAX_BLOCKS_RESET;
    end else if (psel && penable && pwrite && paddr[CFG_AW-1:2] == REG_MAX_BLOCKS) begin
      max_blocks_r <= pwdata[15:0];
    end
  end

  bpa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .max_blocks  (max_blocks_r),
    .map_req     (map_req),
    .map_rd_data (map_rd_data)
  );

  bpa_map_ram u_map (
    .clk       (clk),
    .req       (map_req),
    .rd_data_r (map_rd_data)
  );

endmodule

FILE: sv/bpa_port_check.sv
`include "bitmap_page_allocator_assert.svh"

module bpa_port_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bpa_pkg::out_item_t out_data
);
  import bpa_pkg::*;

  `BPA_ASSERT_HOLDS(a_addr_only_done, clk, rst_n, out_valid && out_data.block_addr != 32'd0, out_data.status == ST_DONE)
  `BPA_ASSERT_HOLDS(a_addr_aligned, clk, rst_n, out_valid, out_data.block_addr[BLOCK_SHIFT-1:0] == '0)
  `BPA_ASSERT_HOLDS(a_count_bound, clk, rst_n, out_valid, out_data.used_count <= 16'(NUM_BLOCKS))
  `BPA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
  `BPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind bitmap_page_allocator bpa_port_check u_port_check (.*);

FILE: tb/bitmap_page_allocator_tb.sv
module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned RANDOM_ITEMS = 500;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bitmap_page_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow allocator state
  bit block_used [NUM_BLOCKS];
  int unsigned used_total;
  int unsigned next_hint;
  bit map_ready;
  int unsigned block_limit;
  logic [15:0] max_blocks_reg;

  out_item_t pending_results[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_left % 24) < 18;
    endcase
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.status !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, out_data.status);
          error_count++;
        end
        if (out_data.block_addr !== exp_r.block_addr) begin
          $error("block_addr expected %h got %h", exp_r.block_addr, out_data.block_addr);
          error_count++;
        end
        if (out_data.used_count !== exp_r.used_count) begin
          $error("used_count expected %0d got %0d", exp_r.used_count, out_data.used_count);
          error_count++;
        end
      end
    end
  end

  function automatic logic [31:0] floor_block(logic [31:0] v);
    return v - v % BLOCK_BYTES;
  endfunction

  function automatic logic [31:0] ceil_block(logic [31:0] v);
    return floor_block(v + (BLOCK_BYTES - 1));
  endfunction

  function automatic int unsigned clamp_index(logic [31:0] stop);
    int unsigned idx;
    idx = stop / BLOCK_BYTES;
    return (idx > block_limit) ? block_limit : idx;
  endfunction

  function automatic void release_blocks(int unsigned first, int unsigned last, bit lower);
    for (int unsigned i = first; i < last; i++) begin
      if (block_used[i]) begin
        block_used[i] = 1'b0;
        if (used_total > 0) used_total--;
        if (lower && i < next_hint) next_hint = i;
      end
    end
  endfunction

  function automatic bit grab_block(int unsigned i, ref logic [31:0] baddr);
    if (block_used[i]) return 1'b0;
    block_used[i] = 1'b1;
    used_total++;
    next_hint = i + 1;
    baddr = i * BLOCK_BYTES;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_request(in_item_t it);
    out_item_t r;
    logic [31:0] start, stop, baddr;
    int unsigned first, last, h;
    bit found;
    r.status = ST_DONE;
    baddr = '0;
    found = 1'b0;
    if (it.req_type > REQ_FREE_REGION) begin
      r.status = ST_IGNORED;
    end else if (it.req_type != REQ_INIT && !map_ready) begin
      r.status = ST_NOT_READY;
    end else begin
      case (it.req_type)
        REQ_INIT: begin
          foreach (block_used[i]) block_used[i] = 1'b1;
          block_limit = (max_blocks_reg > NUM_BLOCKS) ? NUM_BLOCKS : max_blocks_reg;
          used_total = block_limit;
          next_hint = 0;
          map_ready = 1'b1;
        end
        REQ_ALLOC: begin
          if (used_total < block_limit) begin
            h = next_hint;
            for (int unsigned i = h; i < block_limit && !found; i++)
              found = grab_block(i, baddr);
            for (int unsigned i = 0; i < h && i < block_limit && !found; i++)
              found = grab_block(i, baddr);
          end
          if (!found) r.status = ST_FULL;
        end
        REQ_FREE_BLOCK: begin
          first = it.addr / BLOCK_BYTES;
          if (first >= block_limit) r.status = ST_IGNORED;
          else release_blocks(first, first + 1, 1'b1);
        end
        REQ_ADD_REGION: begin
          start = ceil_block(it.addr);
          stop = floor_block(it.addr + it.size);
          first = start / BLOCK_BYTES;
          last = clamp_index(stop);
          if (start >= stop || first >= last) r.status = ST_IGNORED;
          else release_blocks(first, last, 1'b0);
        end
        REQ_RESERVE_REGION: begin
          start = floor_block(it.addr);
          stop = ceil_block(it.addr + it.size);
          first = start / BLOCK_BYTES;
          last = clamp_index(stop);
          if (first >= last) begin
            r.status = ST_IGNORED;
          end else begin
            for (int unsigned i = first; i < last; i++) begin
              if (!block_used[i]) begin
                block_used[i] = 1'b1;
                used_total++;
              end
            end
          end
        end
        default: begin
          start = floor_block(it.addr);
          stop = ceil_block(it.addr + it.size);
          first = start / BLOCK_BYTES;
          last = clamp_index(stop);
          if (it.size == 0 || stop <= start || first >= last) r.status = ST_IGNORED;
          else release_blocks(first, last, 1'b1);
        end
      endcase
    end
    r.block_addr = baddr;
    r.used_count = used_total[15:0];
    return r;
  endfunction

  task automatic send_request(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_request(it));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    end
  endtask

  task automatic send_req(logic [2:0] req, logic [31:0] addr, logic [31:0] size);
    in_item_t it;
    it.req_type = req;
    it.addr = addr;
    it.size = size;
    send_request(it);
  endtask

  task automatic drain_results();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_blocks(logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(REG_MAX_BLOCKS) << 2;
    pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    max_blocks_reg = value;
  endtask

  task automatic test_before_init();
    send_req(REQ_ALLOC, 32'h0, 32'h0);
    send_req(REQ_FREE_BLOCK, 32'h0, 32'h0);
    send_req(REQ_ADD_REGION, 32'h0, 32'h10000);
    send_req(REQ_RESERVE_REGION, 32'h1000, 32'h1000);
    send_req(REQ_FREE_REGION, 32'h1000, 32'h1000);
    send_req(REQ_SPARE_LO, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_req(REQ_SPARE_HI, 32'h0, 32'h0);
  endtask

  task automatic test_directed();
    send_req(REQ_INIT, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_req(REQ_ALLOC, 32'h0, 32'h0);
    send_req(REQ_ADD_REGION, 32'h0, 32'h8000);
    send_req(REQ_ALLOC, 32'h0, 32'h0);
    send_req(REQ_ALLOC, 32'h0, 32'h0);
    send_req(REQ_FREE_BLOCK, 32'h0, 32'h0);
    send_req(REQ_FREE_BLOCK, 32'h0FFF, 32'h0);
    send_req(REQ_FREE_BLOCK, 32'hFFFFFFFF, 32'h0);
    send_req(REQ_ADD_REGION, 32'h1001, 32'h1000);
    send_req(REQ_ADD_REGION, 32'hFFFFF000, 32'h3000);
    send_req(REQ_ADD_REGION, 32'h7FFF000, 32'h2000);
    send_req(REQ_RESERVE_REGION, 32'hFFFFF001, 32'h2000);
    send_req(REQ_RESERVE_REGION, 32'h0, 32'h0);
    send_req(REQ_RESERVE_REGION, 32'h0FFF, 32'h2);
    send_req(REQ_FREE_REGION, 32'h3000, 32'h0);
    send_req(REQ_FREE_REGION, 32'hFFFFF000, 32'h2000);
    send_req(REQ_FREE_REGION, 32'h2001, 32'h3000);
    send_req(REQ_ALLOC, 32'h0, 32'h0);
    send_req(REQ_FREE_REGION, 32'h7FFE000, 32'h4000);
    send_req(REQ_ALLOC, 32'h0, 32'h0);
    send_req(REQ_ALLOC, 32'h0, 32'h0);
    send_req(REQ_SPARE_HI, 32'h0, 32'h0);
  endtask

  task automatic test_small_limits();
    drain_results();
    write_max_blocks(16'd0);
    send_req(REQ_INIT, 32'h0, 32'h0);
    send_req(REQ_ADD_REGION, 32'h0, 32'hFFFFFFFF);
    send_req(REQ_ALLOC, 32'h0, 32'h0);
    send_req(REQ_FREE_BLOCK, 32'h0, 32'h0);
    drain_results();
    write_max_blocks(16'd3);
    send_req(REQ_INIT, 32'h0, 32'h0);
    send_req(REQ_FREE_REGION, 32'h0, 32'hFFFFFFFF);
    for (int k = 0; k < 5; k++) send_req(REQ_ALLOC, 32'h0, 32'h0);
    send_req(REQ_FREE_BLOCK, 32'h3000, 32'h0);
    drain_results();
    write_max_blocks(16'hFFFF);
    send_req(REQ_INIT, 32'h0, 32'h0);
    send_req(REQ_FREE_REGION, 32'h7FFF000, 32'h1000);
    send_req(REQ_ALLOC, 32'h0, 32'h0);
  endtask

  function automatic in_item_t random_request();
    in_item_t it;
    int unsigned pick, span;
    pick = $urandom_range(0, 99);
    span = block_limit + 4;
    if (pick < 3) it.req_type = REQ_INIT;
    else if (pick < 38) it.req_type = REQ_ALLOC;
    else if (pick < 56) it.req_type = REQ_FREE_BLOCK;
    else if (pick < 66) it.req_type = REQ_ADD_REGION;
    else if (pick < 76) it.req_type = REQ_RESERVE_REGION;
    else if (pick < 92) it.req_type = REQ_FREE_REGION;
    else if (pick < 95) it.req_type = ($urandom_range(0, 1) != 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
    else it.req_type = 3'($urandom_range(0, 7));
    it.addr = $urandom_range(0, span - 1) * BLOCK_BYTES;
    if ($urandom_range(0, 2) == 0) it.addr += $urandom_range(0, BLOCK_BYTES - 1);
    it.size = $urandom_range(0, 12) * BLOCK_BYTES;
    if ($urandom_range(0, 2) == 0) it.size += $urandom_range(0, BLOCK_BYTES - 1);
    if ($urandom_range(0, 11) == 0) begin
      it.addr = $urandom;
      it.size = $urandom;
    end
    return it;
  endfunction

  task automatic test_random();
    int unsigned phase_items;
    int unsigned sent;
    logic [15:0] cfg;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 3))
        0: cfg = 16'd32768;
        1: cfg = 16'($urandom_range(1, 64));
        2: cfg = 16'($urandom);
        default: cfg = 16'($urandom_range(100, 2000));
      endcase
      write_max_blocks(cfg);
      send_req(REQ_INIT, $urandom, $urandom);
      send_req(REQ_ADD_REGION, 32'h0, $urandom_range(4, 40) * BLOCK_BYTES);
      phase_items = $urandom_range(60, 120);
      for (int unsigned k = 0; k < phase_items && sent < RANDOM_ITEMS; k++) begin
        send_request(random_request());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    foreach (block_used[i]) block_used[i] = 1'b1;
    used_total = 0;
    next_hint = 0;
    map_ready = 1'b0;
    block_limit = NUM_BLOCKS;
    max_blocks_reg = MAX_BLOCKS_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_init();
    test_directed();
    test_small_limits();
    test_random();
    drain_results();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
